// ----- rtl/fpba_pkg.sv -----
package fpba_pkg;

   // default sizing
   localparam int MAX_BLOCKS_DEF = 32;
   localparam int SIZE_BITS_DEF  = 16;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 6;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FIT_MODE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_BLOCK_COUNT = 2'd1;

   localparam logic [5:0] BLOCK_COUNT_RESET = 6'd32;

   // placement policy; the unused code behaves as first fit
   typedef enum logic [1:0] {
      MODE_FIRST = 2'd0,
      MODE_BEST  = 2'd1,
      MODE_WORST = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_LOADED    = 2'd0,
      STATUS_ALLOCATED = 2'd1,
      STATUS_NOFIT     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_DONE = 2'd2
   } state_type;

   typedef struct packed {
      logic        func;
      logic [4:0]  block_index;
      logic [15:0] size;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  chosen_block;
      logic [15:0] remaining;
   } rsp_type;

endpackage

// ----- rtl/fpba_cell.sv -----
module fpba_cell #(
   parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF,
   parameter int IDX_BITS   = 5,
   parameter int CELL_INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           mode,
   input  logic [5:0]           block_count,
   input  logic [SIZE_BITS-1:0] req_size,
   input  logic [1+IDX_BITS+SIZE_BITS-1:0] commit_in,
   input  logic [2+IDX_BITS+SIZE_BITS-1:0] cand_in,
   output logic [2+IDX_BITS+SIZE_BITS-1:0] cand_out
);

   typedef struct packed {
      logic                 live;
      logic                 found;
      logic [IDX_BITS-1:0]  pick;
      logic [SIZE_BITS-1:0] val;
   } cand_type;

   typedef struct packed {
      logic                 we;
      logic [IDX_BITS-1:0]  index;
      logic [SIZE_BITS-1:0] value;
   } commit_type;

   cand_type   cin;
   cand_type   cand_ff;
   cand_type   cand_in_next;
   commit_type cmt;

   logic [SIZE_BITS-1:0] free_ff;
   logic [SIZE_BITS-1:0] free_in;
   logic                 active;
   logic                 fits;
   logic                 take;

   assign cin      = cand_type'(cand_in);
   assign cmt      = commit_type'(commit_in);
   assign cand_out = cand_ff;

   // only blocks below the in-use count take part
   assign active = 9'(CELL_INDEX) < {3'b000, block_count};
   assign fits   = cin.live && active && (req_size <= free_ff);

   always_comb begin
      take = 1'b0;
      if (fits) begin
         if (!cin.found) begin
            take = 1'b1;
         end else if (mode == fpba_pkg::MODE_BEST) begin
            take = free_ff < cin.val;
         end else if (mode == fpba_pkg::MODE_WORST) begin
            take = free_ff > cin.val;
         end
      end
   end

   always_comb begin
      cand_in_next = cin;
      if (take) begin
         cand_in_next.found = 1'b1;
         cand_in_next.pick  = IDX_BITS'(CELL_INDEX);
         cand_in_next.val   = free_ff;
      end
   end

   always_comb begin
      free_in = free_ff;
      if (cmt.we && (cmt.index == IDX_BITS'(CELL_INDEX))) begin
         free_in = cmt.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff      <= '0;
         cand_ff.live <= 1'b0;
      end else begin
         free_ff      <= free_in;
         cand_ff.live <= cand_in_next.live;
      end
      cand_ff.found <= cand_in_next.found;
      cand_ff.pick  <= cand_in_next.pick;
      cand_ff.val   <= cand_in_next.val;
   end

endmodule

// ----- rtl/fit_policy_block_allocator_unit.sv -----
// Block allocator with first, best and worst fit placement. Each of MAX_BLOCKS cells in a row
// holds one block's free size. A load beat goes straight to the finishing state, where it writes
// one block and answers once the output register is free. A request beat sends a search token
// down the row, one cell per cycle; each cell in use checks the requested size against its
// block and hands the best candidate so far to its neighbor. When the token leaves the last
// cell its result is captured; the chosen block is charged and the result written when the
// output register is free. One item is in flight at a time; the next beat is taken as soon as the
// result sits in the output register, even while that result waits to be taken. fit_mode
// selects the policy (code 3 acts as first fit), block_count limits the scan to the low blocks,
// and ties go to the lowest index. Write the configuration only while the block is idle.
module fit_policy_block_allocator_unit #(
   parameter int MAX_BLOCKS = fpba_pkg::MAX_BLOCKS_DEF,
   parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  fpba_pkg::req_type                   req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fpba_pkg::rsp_type                   rsp_data,
   // configuration writes
   input  logic                                csr_we,
   input  logic [fpba_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fpba_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int IDX_BITS = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int IW       = (IDX_BITS > 5) ? IDX_BITS : 5;    // index widening width
   localparam int VW       = (SIZE_BITS > 16) ? SIZE_BITS : 16; // size widening width
   localparam int CAND_W   = 2 + IDX_BITS + SIZE_BITS;
   localparam int CMT_W    = 1 + IDX_BITS + SIZE_BITS;

   // search token handed cell to cell
   typedef struct packed {
      logic                 live;
      logic                 found;
      logic [IDX_BITS-1:0]  pick;
      logic [SIZE_BITS-1:0] val;
   } cand_type;

   // write-back to one cell
   typedef struct packed {
      logic                 we;
      logic [IDX_BITS-1:0]  index;
      logic [SIZE_BITS-1:0] value;
   } commit_type;

   fpba_pkg::state_type state_ff;
   fpba_pkg::state_type state_in;

   logic [1:0]        fit_mode_ff;
   logic [5:0]        block_count_ff;
   fpba_pkg::req_type req_ff;
   logic              start_ff;
   logic              start_in;

   // captured result of the scan
   logic                 found_ff;
   logic [IDX_BITS-1:0]  pick_ff;
   logic [SIZE_BITS-1:0] val_ff;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   fpba_pkg::rsp_type rsp_data_ff;
   fpba_pkg::rsp_type rsp_next;

   logic accept;
   logic out_free;
   logic load_ok;
   logic emit;

   logic [SIZE_BITS-1:0] req_val;
   logic [SIZE_BITS-1:0] left_val;
   logic [VW-1:0]        size_wide;
   logic [VW-1:0]        rem_wide;
   logic [IW-1:0]        load_idx_wide;
   logic [IW-1:0]        pick_wide;

   commit_type commit;
   cand_type   chain [MAX_BLOCKS+1];
   logic [MAX_BLOCKS-1:0] live_vec;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // request size kept to SIZE_BITS
   assign size_wide = VW'(req_ff.size);
   assign req_val   = size_wide[SIZE_BITS-1:0];

   // load index into the table range
   assign load_idx_wide = IW'(req_ff.block_index);
   assign load_ok       = {4'b0000, req_ff.block_index} < 9'(MAX_BLOCKS);
   assign pick_wide     = IW'(pick_ff);
   assign left_val      = val_ff - req_val;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff    <= fpba_pkg::MODE_FIRST;
         block_count_ff <= fpba_pkg::BLOCK_COUNT_RESET;
      end else if (csr_we) begin
         if (csr_index == fpba_pkg::REG_FIT_MODE) begin
            fit_mode_ff <= csr_wdata[1:0];
         end else if (csr_index == fpba_pkg::REG_BLOCK_COUNT) begin
            block_count_ff <= csr_wdata[5:0];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fpba_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = req_data.func ? fpba_pkg::ST_SCAN : fpba_pkg::ST_DONE;
            end
         end
         fpba_pkg::ST_SCAN: begin
            if (chain[MAX_BLOCKS].live) begin
               state_in = fpba_pkg::ST_DONE;
            end
         end
         fpba_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = fpba_pkg::ST_IDLE;
            end
         end
         default: state_in = fpba_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      emit      = 1'b0;
      case (state_ff)
         fpba_pkg::ST_IDLE: req_stall = 1'b0;
         fpba_pkg::ST_SCAN: req_stall = 1'b1;
         fpba_pkg::ST_DONE: emit      = out_free;
         default:           req_stall = 1'b1;
      endcase
   end

   // result and write-back for the finished item
   always_comb begin
      rsp_next     = '0;
      commit       = '0;
      commit.index = pick_ff;
      commit.value = left_val;
      if (!req_ff.func) begin
         rsp_next.status       = fpba_pkg::STATUS_LOADED;
         rsp_next.chosen_block = req_ff.block_index;
         commit.index          = load_idx_wide[IDX_BITS-1:0];
         commit.value          = req_val;
         if (load_ok) begin
            rem_wide           = VW'(req_val);
            rsp_next.remaining = rem_wide[15:0];
            commit.we          = emit;
         end else begin
            rem_wide = '0;
         end
      end else if (found_ff) begin
         rem_wide              = VW'(left_val);
         rsp_next.status       = fpba_pkg::STATUS_ALLOCATED;
         rsp_next.chosen_block = pick_wide[4:0];
         rsp_next.remaining    = rem_wide[15:0];
         commit.we             = emit;
      end else begin
         rem_wide        = '0;
         rsp_next.status = fpba_pkg::STATUS_NOFIT;
      end
   end

   // a request launches the token in the cycle after acceptance
   assign start_in = accept && req_data.func;

   assign chain[0] = '{live: start_ff, found: 1'b0, pick: '0, val: '0};

   for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      fpba_cell #(
         .SIZE_BITS  (SIZE_BITS),
         .IDX_BITS   (IDX_BITS),
         .CELL_INDEX (k)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .mode        (fit_mode_ff),
         .block_count (block_count_ff),
         .req_size    (req_val),
         .commit_in   (CMT_W'(commit)),
         .cand_in     (CAND_W'(chain[k])),
         .cand_out    (chain[k+1])
      );
      assign live_vec[k] = chain[k+1].live;
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpba_pkg::ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (accept) begin
         found_ff <= 1'b0;
      end else if ((state_ff == fpba_pkg::ST_SCAN) && chain[MAX_BLOCKS].live) begin
         found_ff <= chain[MAX_BLOCKS].found;
         pick_ff  <= chain[MAX_BLOCKS].pick;
         val_ff   <= chain[MAX_BLOCKS].val;
      end
      if (emit) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new result beat only follows the finishing state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == fpba_pkg::ST_DONE))
      else $error("result beat without a finished item");

   // the token leaves the row only during a scan
   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      chain[MAX_BLOCKS].live |-> (state_ff == fpba_pkg::ST_SCAN))
      else $error("search token outside a scan");

   // never more than one token in the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(live_vec))
      else $error("more than one search token in flight");

   // a chosen block always covers the request
   a_fit_covers: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == fpba_pkg::ST_DONE) && req_ff.func && found_ff) |-> (val_ff >= req_val))
      else $error("chosen block smaller than the request");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

// checks the block allocator against a mirror of its free-size table: every accepted beat
// is run through the mirror and the result it should give is queued, and every result beat
// is compared with the oldest queued one
module tb;

   localparam int TABLE_DEPTH   = fpba_pkg::MAX_BLOCKS_DEF;
   localparam int SCAN_LATENCY  = TABLE_DEPTH + 2;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_BEATS   = 50;
   localparam int REPORT_LIMIT  = 10;

   // operation codes carried in the func field
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   // policy code with no meaning of its own, acts as first fit
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // register indexes beyond the list, writes there must do nothing
   localparam logic [fpba_pkg::CSR_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
   localparam logic [fpba_pkg::CSR_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   fpba_pkg::req_type req_data  = '0;

   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   fpba_pkg::rsp_type rsp_data;

   logic                                csr_we    = 1'b0;
   logic [fpba_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [fpba_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // mirror of the block: free sizes and the two registers
   logic [15:0] free_mirror [TABLE_DEPTH];
   logic [1:0]  mode_mirror;
   logic [5:0]  count_mirror;

   // results owed by the block, oldest first
   fpba_pkg::rsp_type placement_q [$];

   int mismatch_count = 0;
   bit calm = 1'b0;   // no idling on either side while set

   fit_policy_block_allocator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // run one beat through the mirror and give the result it must produce
   function automatic fpba_pkg::rsp_type place_item(fpba_pkg::req_type item);
      fpba_pkg::rsp_type res;
      int                scan_len;
      bit                hit;
      int                pick;
      res  = '0;
      hit  = 1'b0;
      pick = 0;
      if (item.func == OP_LOAD) begin
         free_mirror[item.block_index] = item.size;
         res.status       = fpba_pkg::STATUS_LOADED;
         res.chosen_block = item.block_index;
         res.remaining    = item.size;
         return res;
      end
      // counts above the table depth are clamped
      scan_len = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : count_mirror;
      for (int j = 0; j < scan_len; j++) begin
         if (item.size <= free_mirror[j]) begin
            if (!hit) begin
               hit  = 1'b1;
               pick = j;
            end else if (mode_mirror == fpba_pkg::MODE_BEST &&
                         free_mirror[j] < free_mirror[pick]) begin
               pick = j;
            end else if (mode_mirror == fpba_pkg::MODE_WORST &&
                         free_mirror[j] > free_mirror[pick]) begin
               pick = j;
            end
         end
      end
      if (!hit) begin
         res.status = fpba_pkg::STATUS_NOFIT;
         return res;
      end
      free_mirror[pick] = free_mirror[pick] - item.size;
      res.status       = fpba_pkg::STATUS_ALLOCATED;
      res.chosen_block = pick[4:0];
      res.remaining    = free_mirror[pick];
      return res;
   endfunction

   function automatic int scan_limit();
      return (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : count_mirror;
   endfunction

   // result side: random stall, with none while calm
   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 30);
   end

   // sample both channels at the rising edge; results are checked before the
   // new beat is mirrored so the oldest expectation is always the one compared
   always @(posedge clock) begin
      fpba_pkg::rsp_type owed;
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (placement_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected result beat: status %0d block %0d remaining %0d",
                           rsp_data.status, rsp_data.chosen_block, rsp_data.remaining);
            end else begin
               owed = placement_q.pop_front();
               if (rsp_data.status !== owed.status ||
                   rsp_data.chosen_block !== owed.chosen_block ||
                   rsp_data.remaining !== owed.remaining) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"result mismatch: expected status %0d block %0d ",
                               "remaining %0d, got status %0d block %0d remaining %0d"},
                              owed.status, owed.chosen_block, owed.remaining,
                              rsp_data.status, rsp_data.chosen_block, rsp_data.remaining);
               end
            end
         end
         if (req_valid === 1'b1 && req_stall === 1'b0)
            placement_q.push_back(place_item(req_data));
      end
   end

   // offer one beat and hold it until it is taken; returns at the accepting edge
   task automatic send_beat(input logic func, input logic [4:0] idx, input logic [15:0] size);
      fpba_pkg::req_type item;
      item.func        = func;
      item.block_index = idx;
      item.size        = size;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   // drop valid and wait until every owed result has come back
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (placement_q.size() != 0) @(posedge clock);
   endtask

   // register write, only while nothing is in flight
   task automatic write_reg(input logic [fpba_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [fpba_pkg::CSR_DATA_BITS-1:0] data);
      wait_quiet();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == fpba_pkg::REG_FIT_MODE)
         mode_mirror = data[1:0];
      else if (idx == fpba_pkg::REG_BLOCK_COUNT)
         count_mirror = data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // fresh table is all zero: only a zero-size request fits
   task automatic test_empty_table();
      send_beat(OP_ALLOC, 5'd0, 16'd0);
      send_beat(OP_ALLOC, 5'd17, 16'd1);
      send_beat(OP_ALLOC, 5'd31, 16'hFFFF);
   endtask

   // same table under each policy, ties included
   task automatic test_fit_policies();
      send_beat(OP_LOAD, 5'd31, 16'hFFFF);
      send_beat(OP_LOAD, 5'd3, 16'd100);
      send_beat(OP_LOAD, 5'd7, 16'd100);
      send_beat(OP_LOAD, 5'd10, 16'd500);
      send_beat(OP_LOAD, 5'd12, 16'd500);
      send_beat(OP_ALLOC, 5'd0, 16'd60);      // first fit takes block 3
      write_reg(fpba_pkg::REG_FIT_MODE, 6'(fpba_pkg::MODE_BEST));
      send_beat(OP_ALLOC, 5'd0, 16'd40);      // smallest that fits
      send_beat(OP_ALLOC, 5'd0, 16'd100);     // exact fit
      send_beat(OP_ALLOC, 5'd0, 16'd0);       // zero size, smallest block in use
      write_reg(fpba_pkg::REG_FIT_MODE, 6'(fpba_pkg::MODE_WORST));
      send_beat(OP_ALLOC, 5'd0, 16'hFFFF);    // drains the largest block
      send_beat(OP_ALLOC, 5'd0, 16'd1);       // tie between the two 500 blocks
      write_reg(fpba_pkg::REG_FIT_MODE, 6'(MODE_SPARE));
      send_beat(OP_ALLOC, 5'd0, 16'd200);
      send_beat(OP_ALLOC, 5'd0, 16'd40000);   // nothing left that big
      write_reg(fpba_pkg::REG_FIT_MODE, 6'(fpba_pkg::MODE_FIRST));
   endtask

   // scan length: zero, one, clamped, and entries loaded past the count
   task automatic test_block_count_limits();
      write_reg(fpba_pkg::REG_BLOCK_COUNT, 6'd0);
      send_beat(OP_ALLOC, 5'd0, 16'd0);
      write_reg(fpba_pkg::REG_BLOCK_COUNT, 6'd1);
      send_beat(OP_ALLOC, 5'd0, 16'd0);
      write_reg(fpba_pkg::REG_BLOCK_COUNT, 6'd4);
      send_beat(OP_LOAD, 5'd8, 16'd9000);
      send_beat(OP_ALLOC, 5'd0, 16'd9000);
      write_reg(fpba_pkg::REG_BLOCK_COUNT, 6'd9);
      send_beat(OP_ALLOC, 5'd0, 16'd9000);
      write_reg(fpba_pkg::REG_BLOCK_COUNT, 6'd63);
      send_beat(OP_LOAD, 5'd30, 16'd7);
      send_beat(OP_ALLOC, 5'd0, 16'd7);
      // writes to unknown indexes leave both registers alone
      write_reg(REG_SPARE_A, 6'h3F);
      write_reg(REG_SPARE_B, 6'h00);
      send_beat(OP_LOAD, 5'd0, 16'd5);
      send_beat(OP_ALLOC, 5'd0, 16'd5);
      write_reg(fpba_pkg::REG_BLOCK_COUNT, 6'd32);
   endtask

   // random load or request, shaped so requests often fit and often tie
   task automatic random_beat();
      int          pick;
      int          lim;
      logic [15:0] base;
      logic [4:0]  idx;
      logic [15:0] size;
      lim  = scan_limit();
      base = free_mirror[$urandom_range(TABLE_DEPTH - 1)];
      idx  = 5'($urandom_range(31));
      pick = $urandom_range(99);
      if ($urandom_range(99) < 40) begin
         if (lim > 0 && $urandom_range(99) < 70)
            idx = 5'($urandom_range(lim - 1));
         if (pick < 50)
            size = 16'($urandom_range(16'hFFFF));
         else if (pick < 80)
            size = 16'($urandom_range(1023));
         else
            size = base;                       // duplicate for ties
         send_beat(OP_LOAD, idx, size);
      end else begin
         if (pick < 30)
            size = 16'($urandom_range(255));
         else if (pick < 60)
            size = base;                       // exact fit
         else if (pick < 80)
            size = base >> 1;
         else
            size = 16'($urandom_range(16'hFFFF));
         send_beat(OP_ALLOC, idx, size);
      end
   endtask

   // phases of random beats, registers changed between phases
   task automatic test_random_traffic();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_reg(fpba_pkg::REG_FIT_MODE, 6'(p % 4));
         case (p % 5)
            0: write_reg(fpba_pkg::REG_BLOCK_COUNT, 6'd32);
            1: write_reg(fpba_pkg::REG_BLOCK_COUNT, 6'($urandom_range(1, 8)));
            2: write_reg(fpba_pkg::REG_BLOCK_COUNT, 6'd63);
            3: write_reg(fpba_pkg::REG_BLOCK_COUNT, 6'($urandom_range(9, 31)));
            default: write_reg(fpba_pkg::REG_BLOCK_COUNT, 6'd1);
         endcase
         calm = (p == 4);   // one long stretch with back-to-back beats
         for (int k = 0; k < PHASE_BEATS; k++) random_beat();
         calm = 1'b0;
      end
   endtask

   initial begin
      for (int j = 0; j < TABLE_DEPTH; j++) free_mirror[j] = '0;
      mode_mirror  = fpba_pkg::MODE_FIRST;
      count_mirror = fpba_pkg::BLOCK_COUNT_RESET;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_fit_policies();
      test_block_count_limits();
      test_random_traffic();

      // drain, then give any stray beat time to show up
      wait_quiet();
      repeat (SCAN_LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0 && placement_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // hang guard
   initial begin
      #1000000;
      $display("Verification failed");
      $finish;
   end

endmodule
